// ===== hw/rtl/aawl_pkg.sv =====
// Shared types and constants for the acyclic automaton word lookup block.
// Depends on nothing; the datapath, controller, top level and testbench import it.
`timescale 1ns / 1ps

package aawl_pkg;

    localparam int NODE_ADDR_BITS_DEF = 16;
    localparam int LINK_ADDR_BITS_DEF = 16;

    localparam logic [31:0] LIST_END    = 32'hFF00_0000;
    localparam logic [31:0] TARGET_MASK = 32'h00FF_FFFF;
    localparam logic [31:0] FINAL_BIT   = 32'h8000_0000;
    localparam logic [31:0] START_MASK  = 32'h7FFF_FFFF;
    localparam int          LABEL_SHIFT = 24;

    typedef enum logic [1:0] {
        OP_WR_NODE = 2'd0,
        OP_WR_LINK = 2'd1,
        OP_LETTER  = 2'd2,
        OP_END     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NODE0_RD,
        ST_NODE0_CAP,
        ST_SCAN_START,
        ST_LINK_CHK,
        ST_NODE_CAP,
        ST_END_RD,
        ST_END_CAP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic node0_rd;
        logic node_cap;
        logic found_from_node;
        logic scan_start;
        logic scan_next;
        logic target_rd;
        logic set_fail;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic valid;
        op_t  op;
        logic out_free;
        logic failed;
        logic at_start;
        logic start_bad;
        logic list_end;
        logic label_hit;
        logic target_bad;
        logic next_bad;
    } dp_status_t;

endpackage

// ===== hw/rtl/aawl_cmd_if.sv =====
// Request channel of the word lookup block: valid/ready plus the request fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface aawl_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] table_address;
    logic [31:0] table_word;
    logic [7:0]  letter;

    modport source (output valid, output operation, output table_address,
                    output table_word, output letter, input ready);
    modport sink   (input valid, input operation, input table_address,
                    input table_word, input letter, output ready);
endinterface

// ===== hw/rtl/aawl_rsp_if.sv =====
// Result channel of the word lookup block: valid/ready plus the found flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface aawl_rsp_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink   (input valid, input found, output ready);
endinterface

// ===== hw/rtl/aawl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module aawl_ram #(
    parameter int WIDTH     = 32,
    parameter int ADDR_BITS = 16
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_array [0:(64'd1 << ADDR_BITS) - 64'd1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/aawl_datapath.sv =====
// Datapath of the word lookup block: node and link memories, walk registers
// and the result register. Depends on aawl_pkg, aawl_ram and the channel interfaces.
`timescale 1ns / 1ps

module aawl_datapath #(
    parameter int NODE_ADDR_BITS = aawl_pkg::NODE_ADDR_BITS_DEF,
    parameter int LINK_ADDR_BITS = aawl_pkg::LINK_ADDR_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    aawl_cmd_if.sink               cmd,
    aawl_rsp_if.source             rsp,
    input  aawl_pkg::ctrl_cmd_t    ctl,
    output aawl_pkg::dp_status_t   st
);
    import aawl_pkg::*;

    localparam logic [32:0] NODE_DEPTH = 33'd1 << NODE_ADDR_BITS;
    localparam logic [32:0] LINK_DEPTH = 33'd1 << LINK_ADDR_BITS;

    logic [31:0]               cur_word_reg;
    logic [LINK_ADDR_BITS-1:0] idx_reg;
    logic [7:0]                letter_reg;
    logic                      found_reg;
    logic                      failed_reg;
    logic                      failed_next;
    logic                      at_start_reg;
    logic                      at_start_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    logic                      accept;
    op_t                       op;
    logic                      end_now;
    logic [30:0]               start;
    logic [LINK_ADDR_BITS:0]   next_idx;
    logic [31:0]               node_rdata;
    logic [31:0]               link_rdata;
    logic [23:0]               target;
    logic [7:0]                label;

    logic                      node_wr_en;
    logic                      link_wr_en;
    logic                      node_rd_en;
    logic                      link_rd_en;
    logic [NODE_ADDR_BITS-1:0] node_rd_addr;
    logic [LINK_ADDR_BITS-1:0] link_rd_addr;

    assign op      = op_t'(cmd.operation);
    assign accept  = cmd.valid && ctl.ready;
    assign end_now = accept && (op == OP_END) && !at_start_reg;

    assign start    = 31'(cur_word_reg & START_MASK);
    assign next_idx = {1'b0, idx_reg} + {{LINK_ADDR_BITS{1'b0}}, 1'b1};
    assign target   = 24'(link_rdata & TARGET_MASK);
    assign label    = 8'(link_rdata >> LABEL_SHIFT);

    // Writes beyond the table depth are dropped.
    assign node_wr_en = accept && (op == OP_WR_NODE) && (33'(cmd.table_address) < NODE_DEPTH);
    assign link_wr_en = accept && (op == OP_WR_LINK) && (33'(cmd.table_address) < LINK_DEPTH);

    assign node_rd_en   = ctl.node0_rd || ctl.target_rd;
    assign node_rd_addr = ctl.node0_rd ? '0 : target[NODE_ADDR_BITS-1:0];
    assign link_rd_en   = ctl.scan_start || ctl.scan_next;
    assign link_rd_addr = ctl.scan_start ? start[LINK_ADDR_BITS-1:0]
                                         : next_idx[LINK_ADDR_BITS-1:0];

    aawl_ram #(
        .WIDTH     (32),
        .ADDR_BITS (NODE_ADDR_BITS)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_wr_en),
        .wr_addr (NODE_ADDR_BITS'(cmd.table_address)),
        .wr_data (cmd.table_word),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_rdata)
    );

    aawl_ram #(
        .WIDTH     (32),
        .ADDR_BITS (LINK_ADDR_BITS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (LINK_ADDR_BITS'(cmd.table_address)),
        .wr_data (cmd.table_word),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rdata)
    );

    always_comb
    begin
        failed_next = failed_reg;
        if (ctl.set_fail)
        begin
            failed_next = 1'b1;
        end
        else if (end_now)
        begin
            failed_next = 1'b0;
        end

        at_start_next = at_start_reg;
        if (accept && (op == OP_LETTER))
        begin
            at_start_next = 1'b0;
        end
        else if (accept && (op == OP_END))
        begin
            at_start_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (end_now || ctl.found_from_node)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg    <= 1'b0;
            at_start_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            failed_reg    <= failed_next;
            at_start_reg  <= at_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.node_cap)
        begin
            cur_word_reg <= node_rdata;
        end
        if (ctl.scan_start)
        begin
            idx_reg <= start[LINK_ADDR_BITS-1:0];
        end
        else if (ctl.scan_next)
        begin
            idx_reg <= next_idx[LINK_ADDR_BITS-1:0];
        end
        if (accept && (op == OP_LETTER))
        begin
            letter_reg <= cmd.letter;
        end
        if (end_now)
        begin
            found_reg <= !failed_reg && ((cur_word_reg & FINAL_BIT) != 32'd0);
        end
        else if (ctl.found_from_node)
        begin
            found_reg <= (node_rdata & FINAL_BIT) != 32'd0;
        end
    end

    assign cmd.ready = ctl.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.found = found_reg;

    always_comb
    begin
        st.valid      = cmd.valid;
        st.op         = op;
        st.out_free   = !out_valid_reg || rsp.ready;
        st.failed     = failed_reg;
        st.at_start   = at_start_reg;
        st.start_bad  = 33'(start) >= LINK_DEPTH;
        st.list_end   = link_rdata == LIST_END;
        st.label_hit  = label == letter_reg;
        st.target_bad = (target == 24'd0) || (33'(target) >= NODE_DEPTH);
        st.next_bad   = next_idx[LINK_ADDR_BITS];
    end

`ifndef SYNTHESIS
    // A failed word always has at least one letter taken.
    a_fail_not_start: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> !at_start_reg)
        else $error("word marked failed while still at word start");

    // A result appears only from an end request or from the node 0 read it caused.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(cmd.valid && ctl.ready && (op == OP_END))
                                  || $past(ctl.found_from_node)))
        else $error("result raised without an end request");

    // The walk never reads both from node 0 and from a link target at once.
    a_node_read_single: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.node0_rd && ctl.target_rd))
        else $error("two node reads issued in one cycle");
`endif

endmodule

// ===== hw/rtl/aawl_ctrl.sv =====
// Controller of the word lookup block: sequences link scans and node reads.
// Depends on aawl_pkg.
`timescale 1ns / 1ps

module aawl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  aawl_pkg::dp_status_t st,
    output aawl_pkg::ctrl_cmd_t  ctl
);
    import aawl_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        accept     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // An end request needs the result slot; other requests do not.
                ctl.ready = (st.op != OP_END) || st.out_free;
                accept    = st.valid && ctl.ready;
                if (accept)
                begin
                    unique case (st.op)
                        OP_WR_NODE, OP_WR_LINK:
                        begin
                            state_next = ST_IDLE;
                        end
                        OP_LETTER:
                        begin
                            priority if (st.failed)
                            begin
                                state_next = ST_IDLE;
                            end
                            else if (st.at_start)
                            begin
                                state_next = ST_NODE0_RD;
                            end
                            else
                            begin
                                state_next = ST_SCAN_START;
                            end
                        end
                        OP_END:
                        begin
                            state_next = st.at_start ? ST_END_RD : ST_IDLE;
                        end
                    endcase
                end
            end
            ST_NODE0_RD:
            begin
                ctl.node0_rd = 1'b1;
                state_next   = ST_NODE0_CAP;
            end
            ST_NODE0_CAP:
            begin
                ctl.node_cap = 1'b1;
                state_next   = ST_SCAN_START;
            end
            ST_SCAN_START:
            begin
                if (st.start_bad)
                begin
                    ctl.set_fail = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = ST_LINK_CHK;
                end
            end
            ST_LINK_CHK:
            begin
                // One link word is checked per cycle while the next one is read.
                priority if (st.list_end)
                begin
                    ctl.set_fail = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (st.label_hit && st.target_bad)
                begin
                    ctl.set_fail = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (st.label_hit)
                begin
                    ctl.target_rd = 1'b1;
                    state_next    = ST_NODE_CAP;
                end
                else if (st.next_bad)
                begin
                    ctl.set_fail = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ctl.scan_next = 1'b1;
                    state_next    = ST_LINK_CHK;
                end
            end
            ST_NODE_CAP:
            begin
                ctl.node_cap = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_END_RD:
            begin
                ctl.node0_rd = 1'b1;
                state_next   = ST_END_CAP;
            end
            ST_END_CAP:
            begin
                ctl.found_from_node = 1'b1;
                state_next          = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_node_cap_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NODE_CAP) |-> ($past(state_reg) == ST_LINK_CHK))
        else $error("target node captured without a matching link");

    a_end_cap_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_END_CAP) |-> ($past(state_reg) == ST_END_RD))
        else $error("end result taken without a node 0 read");

    a_scan_not_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINK_CHK) |-> !st.at_start)
        else $error("link scan running while at word start");
`endif

endmodule

// ===== hw/rtl/acyclic_automaton_word_lookup.sv =====
// Top level of the acyclic automaton word lookup block.
// Depends on aawl_pkg, aawl_cmd_if, aawl_rsp_if, aawl_ctrl and aawl_datapath.
`timescale 1ns / 1ps

// The block checks query words against a packed acyclic word automaton held in a
// node memory and a link memory, both filled by write requests. A letter request
// scans the link list of the current node for the letter and, on a match, reads
// the target node; the first letter of a word reads node 0 before the scan, and a
// letter after the word has already failed starts no scan. The scan reads one link
// word per cycle from the registered link memory port. An end request reads node 0
// when the word has no letters, and can be taken while an earlier result still
// waits on the result channel only once that result leaves. Memory contents are
// undefined until written; no clearing pass runs.
module acyclic_automaton_word_lookup #(
    parameter int NODE_ADDR_BITS = aawl_pkg::NODE_ADDR_BITS_DEF,
    parameter int LINK_ADDR_BITS = aawl_pkg::LINK_ADDR_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    aawl_cmd_if.sink   cmd,
    aawl_rsp_if.source rsp
);
    import aawl_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t st;

    aawl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctl   (ctl)
    );

    aawl_datapath #(
        .NODE_ADDR_BITS (NODE_ADDR_BITS),
        .LINK_ADDR_BITS (LINK_ADDR_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .ctl   (ctl),
        .st    (st)
    );

endmodule

// ===== tb/sv/tb_acyclic_automaton_word_lookup.sv =====
// Testbench for the acyclic automaton word lookup block: directed lookups, random automata
// with random walks over them, and result channel backpressure, all checked by a predictor.
// Depends on aawl_pkg, aawl_cmd_if, aawl_rsp_if and the block's top level.
`timescale 1ns / 1ps

module tb_acyclic_automaton_word_lookup;
    import aawl_pkg::*;

    localparam int unsigned NODE_DEPTH = 1 << NODE_ADDR_BITS_DEF;
    localparam int unsigned LINK_DEPTH = 1 << LINK_ADDR_BITS_DEF;
    localparam int IDLE_PCT = 6;
    localparam int MAX_SCAN = 64;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;

    aawl_cmd_if cmd_bus ();
    aawl_rsp_if rsp_bus ();

    acyclic_automaton_word_lookup u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // Shadow of the two tables and of the walk state.
    logic [31:0] node_mem [0:NODE_DEPTH-1];
    logic [31:0] link_mem [0:LINK_DEPTH-1];
    bit          node_valid [0:NODE_DEPTH-1];
    bit          link_valid [0:LINK_DEPTH-1];
    logic [31:0] cur_node_word = '0;
    bit          walk_failed = 1'b0;
    bit          word_start = 1'b1;

    bit found_queue [$];

    int  error_count = 0;
    int  requests_sent = 0;
    int  words_checked = 0;
    int  automata_built = 0;
    int  cycle_count = 0;
    int  hold_cycles = 0;
    bit  quiet = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Scans the current node's link list for one letter. Returns 1 with the target node when
    // the letter moves the walk; flags a scan that would touch an entry never written.
    function automatic bit follow_link(input logic [7:0] ch, output int unsigned target,
                                       output bit unwritten);
        int unsigned idx;
        int          steps;
        logic [31:0] lw;
        target = 0;
        unwritten = 1'b0;
        idx = cur_node_word & START_MASK;
        for (steps = 0; steps < MAX_SCAN; steps++)
        begin
            if (idx >= LINK_DEPTH)
                return 1'b0;
            if (!link_valid[idx])
            begin
                unwritten = 1'b1;
                return 1'b0;
            end
            lw = link_mem[idx];
            if (lw == LIST_END)
                return 1'b0;
            if ((lw >> LABEL_SHIFT) == ch)
            begin
                target = lw & TARGET_MASK;
                if (target == 0 || target >= NODE_DEPTH)
                    return 1'b0;
                unwritten = !node_valid[target];
                return 1'b1;
            end
            idx++;
        end
        // Very long scans are kept out of the stimulus.
        unwritten = 1'b1;
        return 1'b0;
    endfunction

    function automatic void predict_lookup(op_t op, logic [15:0] addr, logic [31:0] word,
                                           logic [7:0] ch);
        int unsigned target;
        bit          unwritten;
        // A 16-bit address always falls inside both tables.
        case (op)
            OP_WR_NODE:
            begin
                node_mem[addr] = word;
                node_valid[addr] = 1'b1;
                if (addr == 16'd0 && word_start)
                    cur_node_word = word;
            end
            OP_WR_LINK:
            begin
                link_mem[addr] = word;
                link_valid[addr] = 1'b1;
            end
            OP_LETTER:
            begin
                word_start = 1'b0;
                if (!walk_failed)
                begin
                    if (follow_link(ch, target, unwritten))
                        cur_node_word = node_mem[target];
                    else
                        walk_failed = 1'b1;
                end
            end
            default:
            begin
                found_queue.push_back(!walk_failed && (cur_node_word & FINAL_BIT) != 0);
                cur_node_word = node_mem[0];
                walk_failed = 1'b0;
                word_start = 1'b1;
            end
        endcase
    endfunction

    task automatic send_request(op_t op, logic [15:0] addr, logic [31:0] word,
                                logic [7:0] ch);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.operation <= op;
        cmd_bus.table_address <= addr;
        cmd_bus.table_word <= word;
        cmd_bus.letter <= ch;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        requests_sent++;
        predict_lookup(op, addr, word, ch);
    endtask

    task automatic write_node(logic [15:0] addr, logic [31:0] word);
        send_request(OP_WR_NODE, addr, word, 8'($urandom));
    endtask

    task automatic write_link(logic [15:0] addr, logic [31:0] word);
        send_request(OP_WR_LINK, addr, word, 8'($urandom));
    endtask

    task automatic send_letter(logic [7:0] ch);
        send_request(OP_LETTER, 16'($urandom), $urandom, ch);
    endtask

    task automatic end_word();
        send_request(OP_END, 16'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic send_word(logic [7:0] letters [$]);
        foreach (letters[i])
            send_letter(letters[i]);
        end_word();
    endtask

    // Mostly a label of the current node, so that walks go deep; sometimes any letter.
    function automatic logic [7:0] likely_letter();
        logic [7:0]  labels [$];
        int unsigned idx;
        int          steps;
        idx = cur_node_word & START_MASK;
        for (steps = 0; steps < MAX_SCAN; steps++)
        begin
            if (idx >= LINK_DEPTH || !link_valid[idx] || link_mem[idx] == LIST_END)
                break;
            labels.push_back(link_mem[idx][31:24]);
            idx++;
        end
        if (walk_failed || labels.size() == 0 || $urandom_range(9) == 0)
            return 8'($urandom);
        return labels[$urandom_range(labels.size() - 1)];
    endfunction

    function automatic bit letter_is_safe(logic [7:0] ch);
        int unsigned target;
        bit          unwritten;
        if (walk_failed)
            return 1'b1;
        void'(follow_link(ch, target, unwritten));
        return !unwritten;
    endfunction

    // Lays out a small acyclic automaton at random places in both tables and makes its
    // root node 0. Some links point at node 0 or past the node table on purpose.
    task automatic build_automaton();
        int          n_nodes;
        int          node_base;
        int          link_ptr;
        int          n_links;
        int          i;
        int          j;
        int unsigned target;
        logic [7:0]  lbl;
        logic [31:0] node_word [0:11];
        n_nodes = $urandom_range(12, 3);
        node_base = $urandom_range(NODE_DEPTH - n_nodes, 1);
        link_ptr = $urandom_range(LINK_DEPTH - MAX_SCAN, 0);
        for (i = 0; i < n_nodes; i++)
        begin
            node_word[i] = ($urandom_range(1) ? FINAL_BIT : 32'h0) | 32'(link_ptr);
            n_links = (n_nodes - 1 - i < 4) ? n_nodes - 1 - i : 4;
            n_links = $urandom_range(n_links, 0);
            for (j = 0; j < n_links; j++)
            begin
                lbl = ($urandom_range(3) != 0) ? 8'(8'h61 + $urandom_range(5)) : 8'($urandom);
                target = node_base + $urandom_range(n_nodes - 1, i + 1);
                case ($urandom_range(15))
                    0: target = 0;
                    1: target = $urandom_range(32'h00FF_FFFF, NODE_DEPTH);
                    default: ;
                endcase
                write_link(16'(link_ptr), {lbl, target[23:0]});
                link_ptr++;
            end
            write_link(16'(link_ptr), LIST_END);
            link_ptr++;
        end
        for (i = n_nodes - 1; i >= 0; i--)
            write_node(16'(node_base + i), node_word[i]);
        write_node(16'd0, node_word[0]);
        automata_built++;
    endtask

    task automatic noise_write();
        if ($urandom_range(1))
            write_node(16'($urandom), $urandom);
        else
            write_link(16'($urandom), $urandom);
    endtask

    task automatic walk_words(int n_words);
        int         w;
        int         len;
        int         k;
        logic [7:0] ch;
        for (w = 0; w < n_words; w++)
        begin
            len = $urandom_range(6, 0);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(99) < 3)
                    noise_write();
                ch = likely_letter();
                if (letter_is_safe(ch))
                    send_letter(ch);
            end
            end_word();
        end
    endtask

    task automatic random_phase(int n_requests);
        int stop_at;
        stop_at = requests_sent + n_requests;
        while (requests_sent < stop_at)
        begin
            build_automaton();
            walk_words($urandom_range(30, 10));
        end
    endtask

    // The root list sits at the top of the link table and has no end word, so a letter
    // that matches none of its labels runs off the table.
    task automatic test_table_load();
        write_node(16'd0, 32'h0000_FFFC);
        end_word();
        write_node(16'd0, FINAL_BIT | 32'h0000_FFFC);
        end_word();
        write_link(16'hFFFC, 32'h6100_0001);
        write_link(16'hFFFD, 32'hFFFF_FFFF);
        write_link(16'hFFFE, 32'h7A00_0000);
        write_link(16'hFFFF, 32'h0000_FFFF);
        write_link(16'h0000, LIST_END);
        write_node(16'd1, FINAL_BIT);
        write_node(16'hFFFF, START_MASK);
    endtask

    task automatic test_accepted_word();
        send_word('{8'h61});
    endtask

    task automatic test_lookup_failures();
        send_word('{8'h61, 8'h62});
        send_word('{8'h7A});
        send_word('{8'hFF});
        send_word('{8'h00, 8'h61});
        send_word('{8'h42});
        send_word('{8'h7A, 8'h61});
    endtask

    task automatic test_random_automata();
        random_phase(1050);
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        random_phase(300);
        quiet = 1'b0;
    endtask

    // The receiver holds off while requests keep coming, so end requests back up.
    task automatic test_result_backpressure();
        hold_cycles = 400;
        random_phase(250);
    endtask

    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else
                rsp_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (found_queue.size() == 0)
            begin
                $error("result with no pending end request: found=%0d", rsp_bus.found);
                error_count++;
            end
            else
            begin
                if (rsp_bus.found !== found_queue[0])
                begin
                    $error("found mismatch: expected %0d, actual %0d",
                           found_queue[0], rsp_bus.found);
                    error_count++;
                end
                void'(found_queue.pop_front());
                words_checked++;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("run did not complete within %0d cycles", CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.operation = OP_WR_NODE;
        cmd_bus.table_address = '0;
        cmd_bus.table_word = '0;
        cmd_bus.letter = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_load();
        test_accepted_word();
        test_lookup_failures();
        test_random_automata();
        test_back_to_back();
        test_result_backpressure();

        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (found_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d random automata; checked %0d word results.",
                 requests_sent, automata_built, words_checked);
        $display("Mismatches and unexpected results: %0d.", error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/aawl_pkg.sv
hw/rtl/aawl_cmd_if.sv
hw/rtl/aawl_rsp_if.sv
hw/rtl/aawl_ram.sv
hw/rtl/aawl_datapath.sv
hw/rtl/aawl_ctrl.sv
hw/rtl/acyclic_automaton_word_lookup.sv
tb/sv/tb_acyclic_automaton_word_lookup.sv
